### design/svac_pkg.sv
// Shared types and constants of the synthesizer voice allocator.
// No dependencies; every other design file imports this package.
package svac_pkg;

    localparam int VOICES_DEF        = 18;
    localparam int MIDI_CHANNELS_DEF = 16;

    localparam int VIDX_W  = 5;
    localparam int SLOT_W  = 6;
    localparam int AGE_W   = 24;
    localparam int SCORE_W = 28;
    localparam int PROG_W  = 8;
    localparam int KEY_W   = 7;
    localparam int CHAN_W  = 4;
    localparam int ELAP_W  = 16;

    localparam logic [CHAN_W-1:0]  PERC_CHANNEL = 4'd9;
    localparam logic [KEY_W-1:0]   PERC_LOWEST  = 7'd35;
    localparam logic [PROG_W-1:0]  PERC_BASE    = 8'd128;
    localparam logic [SCORE_W-1:0] FREE_BONUS   = 28'd15000;
    localparam logic [SCORE_W-1:0] PERC_PENALTY = 28'd45;

    typedef enum logic [2:0] {
        OP_NOTE_ON  = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_PROGRAM  = 3'd2,
        OP_ALL_OFF  = 3'd3,
        OP_ADVANCE  = 3'd4
    } op_t;

    typedef enum logic {
        CMD_KEY_ON  = 1'b0,
        CMD_KEY_OFF = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        SM_SCORE,
        SM_KEY,
        SM_SLOT
    } srch_mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RELEASE,
        S_ASSIGN
    } state_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_AGE,
        UPD_RELEASE,
        UPD_ASSIGN
    } upd_kind_t;

    // Broadcast to every cell while a search runs down the chain.
    typedef struct packed {
        srch_mode_t         mode;
        logic [CHAN_W-1:0]  ch;
        logic [KEY_W-1:0]   key;
        logic [SLOT_W-1:0]  slot;
        logic [PROG_W-1:0]  instr;
    } srch_t;

    // One-cycle state update broadcast to every cell.
    typedef struct packed {
        upd_kind_t          kind;
        logic [VIDX_W-1:0]  idx;
        logic [CHAN_W-1:0]  ch;
        logic [KEY_W-1:0]   key;
        logic [PROG_W-1:0]  instr;
        logic [SLOT_W-1:0]  slot_a;
        logic [SLOT_W-1:0]  slot_b;
        logic [ELAP_W-1:0]  elapsed;
    } upd_t;

    // Running best candidate handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [VIDX_W-1:0]  idx;
        logic               busy;
        logic [CHAN_W-1:0]  owner;
        logic [SLOT_W-1:0]  slot;
        logic [PROG_W-1:0]  prog;
    } carry_t;

endpackage

### design/svac_cell.sv
// One voice cell: holds the state of one voice and one stage of the search chain.
// Depends on svac_pkg.
module svac_cell
    import svac_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  srch_t  srch,
    input  upd_t   upd,
    input  carry_t carry_in,
    output carry_t carry_out
);

    logic               busy_reg, busy_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [PROG_W-1:0]  prog_reg, prog_next;
    logic [CHAN_W-1:0]  owner_reg, owner_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               cvalid_reg;
    carry_t             carry_reg, carry_next;

    logic [SCORE_W-1:0] base, score, own;
    logic [AGE_W:0]     age_sum;
    logic               is_me, match_key, match_slot, take;

    assign is_me = (upd.idx == VIDX_W'(IDX));

    always_comb
    begin
        base = ((SCORE_W'(age_reg)) << 2) + SCORE_W'(age_reg);
        if (!busy_reg)
            base = base + FREE_BONUS;
        if (prog_reg == srch.instr)
            base = base + SCORE_W'(1);
        score = base;
        if (!srch.instr[PROG_W-1] && prog_reg[PROG_W-1])
            score = {base[SCORE_W-2:0], 1'b0} + PERC_PENALTY;
        match_key  = busy_reg && (owner_reg == srch.ch) && (key_reg == srch.key);
        match_slot = busy_reg && (owner_reg == srch.ch) && (slot_reg == srch.slot);
        case (srch.mode)
            SM_SCORE: own = score;
            SM_KEY:   own = SCORE_W'(match_key);
            SM_SLOT:  own = SCORE_W'(match_slot);
            default:  own = '0;
        endcase
        // The first cell always takes; later cells take only on a strictly higher score.
        take = (IDX == 0) || (own > carry_in.score);
        carry_next = carry_in;
        if (take)
        begin
            carry_next.score = own;
            carry_next.idx   = VIDX_W'(IDX);
            carry_next.busy  = busy_reg;
            carry_next.owner = owner_reg;
            carry_next.slot  = slot_reg;
            carry_next.prog  = prog_reg;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        age_next   = age_reg;
        prog_next  = prog_reg;
        owner_next = owner_reg;
        key_next   = key_reg;
        slot_next  = slot_reg;
        age_sum    = {1'b0, age_reg} + (AGE_W+1)'(upd.elapsed);
        case (upd.kind)
            UPD_AGE:
            begin
                age_next = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];
            end
            UPD_RELEASE:
            begin
                if (is_me)
                begin
                    busy_next = 1'b0;
                    age_next  = '0;
                end
                else if (busy_reg && owner_reg == upd.ch && slot_reg == upd.slot_a)
                begin
                    // The last note of the channel fills the hole.
                    slot_next = upd.slot_b;
                end
            end
            UPD_ASSIGN:
            begin
                if (is_me)
                begin
                    busy_next  = 1'b1;
                    age_next   = '0;
                    prog_next  = upd.instr;
                    owner_next = upd.ch;
                    key_next   = upd.key;
                    slot_next  = upd.slot_a;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            age_reg    <= '0;
            prog_reg   <= '0;
            owner_reg  <= '0;
            key_reg    <= '0;
            slot_reg   <= '0;
            cvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            age_reg    <= age_next;
            prog_reg   <= prog_next;
            owner_reg  <= owner_next;
            key_reg    <= key_next;
            slot_reg   <= slot_next;
            cvalid_reg <= carry_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (carry_in.valid)
            carry_reg <= carry_next;
    end

    always_comb
    begin
        carry_out       = carry_reg;
        carry_out.valid = cvalid_reg;
    end

endmodule

### design/synth_voice_allocator.sv
// Top level of the synthesizer voice allocator: controller and chain of voice cells.
// Depends on svac_pkg and svac_cell.
//
//   Channel  | Direction | Handshake          | Word
//   ---------+-----------+--------------------+------------------------------------------
//   input    | in        | in_valid/in_ready  | operation, midi_channel, note, velocity,
//            |           |                    | elapsed
//   output   | out       | out_valid/out_ready| command, voice, instrument, tone,
//            |           |                    | key_velocity, owner_channel, last
//
// Every search runs one cell per cycle down the voice chain, and its answer is taken from
// the last cell. A note-off runs a key search and releases the note it finds; a note-on
// runs a key search and a voice scan, with a release before the key-on when a voice is
// stolen, and an all-notes-off runs one search for each note it releases. Reset clears
// all voice and channel state at once; there is no clearing pass. A stalled output holds
// the controller in place until the word is taken; input words are taken only while the
// controller is idle.
module synth_voice_allocator
    import svac_pkg::*;
#(
    parameter int VOICES        = VOICES_DEF,
    parameter int MIDI_CHANNELS = MIDI_CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [CHAN_W-1:0] midi_channel,
    input  logic [KEY_W-1:0]  note,
    input  logic [KEY_W-1:0]  velocity,
    input  logic [ELAP_W-1:0] elapsed,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              command,
    output logic [VIDX_W-1:0] voice,
    output logic [PROG_W-1:0] instrument,
    output logic [KEY_W-1:0]  tone,
    output logic [KEY_W-1:0]  key_velocity,
    output logic [CHAN_W-1:0] owner_channel,
    output logic              last
);

    localparam int CH_W = (MIDI_CHANNELS > 1) ? $clog2(MIDI_CHANNELS) : 1;

    state_t             state_reg, state_next;
    srch_mode_t         mode_reg, mode_next;
    logic               start_reg, start_next;
    logic               is_on_reg, is_on_next;
    logic [CHAN_W-1:0]  ch_reg, ch_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [KEY_W-1:0]   vel_reg, vel_next;
    logic [PROG_W-1:0]  instr_reg, instr_next;

    // Per-channel note count and program, one read address at a time.
    logic [SLOT_W-1:0]  active_reg [MIDI_CHANNELS];
    logic [KEY_W-1:0]   chprog_reg [MIDI_CHANNELS];

    logic               outv_reg, outv_next;
    logic               cmd_reg, cmd_next;
    logic [VIDX_W-1:0]  voice_reg, voice_next;
    logic [PROG_W-1:0]  instr_out_reg, instr_out_next;
    logic [KEY_W-1:0]   tone_reg, tone_next;
    logic [KEY_W-1:0]   kvel_reg, kvel_next;
    logic [CHAN_W-1:0]  owner_reg, owner_next;
    logic               last_reg, last_next;

    srch_t              srch;
    upd_t               upd;
    carry_t             carries [VOICES+1];
    carry_t             win;

    logic               accept, ch_ok, is_on_in, perc_skip, done, hit, out_free, emit;
    logic [CHAN_W-1:0]  rel_ch, rd_ch;
    logic [SLOT_W-1:0]  active_rd;
    logic               act_we, prog_we;
    logic [CH_W-1:0]    act_wa;
    logic [SLOT_W-1:0]  act_wd;
    op_t                op_in;

    assign op_in     = op_t'(operation);
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign ch_ok     = ({1'b0, midi_channel} < (CHAN_W+1)'(MIDI_CHANNELS));
    assign is_on_in  = (op_in == OP_NOTE_ON) && (velocity != '0);
    assign perc_skip = (midi_channel == PERC_CHANNEL) && (note < PERC_LOWEST);
    assign win       = carries[VOICES];
    assign done      = win.valid;
    assign hit       = (win.score != '0);
    assign out_free  = !outv_reg || out_ready;

    // A stolen voice is released on its own channel; everything else on the event channel.
    assign rel_ch    = (mode_reg == SM_SCORE) ? win.owner : ch_reg;
    assign rd_ch     = (state_reg == S_RELEASE) ? rel_ch : ch_reg;
    assign active_rd = active_reg[rd_ch[CH_W-1:0]];

    always_comb
    begin
        srch.mode  = mode_reg;
        srch.ch    = ch_reg;
        srch.key   = key_reg;
        srch.slot  = active_rd;
        srch.instr = instr_reg;
    end

    always_comb
    begin
        carries[0]       = '0;
        carries[0].valid = start_reg;
    end

    for (genvar i = 0; i < VOICES; i++)
    begin : g_cell
        svac_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .srch      (srch),
            .upd       (upd),
            .carry_in  (carries[i]),
            .carry_out (carries[i+1])
        );
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && ch_ok)
                begin
                    if ((is_on_in && !perc_skip) || op_in == OP_NOTE_OFF ||
                        (op_in == OP_NOTE_ON && !is_on_in) || op_in == OP_ALL_OFF)
                        state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (done)
                begin
                    case (mode_reg)
                        SM_KEY:   state_next = (hit == is_on_reg) ? S_IDLE :
                                               (is_on_reg ? S_SEARCH : S_RELEASE);
                        SM_SCORE: state_next = win.busy ? S_RELEASE : S_ASSIGN;
                        SM_SLOT:  state_next = hit ? S_RELEASE : S_IDLE;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_RELEASE:
            begin
                if (out_free)
                begin
                    case (mode_reg)
                        SM_SCORE: state_next = S_ASSIGN;
                        SM_SLOT:  state_next = (active_rd == SLOT_W'(1)) ? S_IDLE : S_SEARCH;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_ASSIGN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        mode_next      = mode_reg;
        start_next     = 1'b0;
        is_on_next     = is_on_reg;
        ch_next        = ch_reg;
        key_next       = key_reg;
        vel_next       = vel_reg;
        instr_next     = instr_reg;
        upd            = '0;
        upd.kind       = UPD_NONE;
        act_we         = 1'b0;
        act_wa         = rd_ch[CH_W-1:0];
        act_wd         = active_rd;
        prog_we        = 1'b0;
        emit           = 1'b0;
        cmd_next       = cmd_reg;
        voice_next     = voice_reg;
        instr_out_next = instr_out_reg;
        tone_next      = tone_reg;
        kvel_next      = kvel_reg;
        owner_next     = owner_reg;
        last_next      = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next    = midi_channel;
                    key_next   = note;
                    vel_next   = velocity;
                    is_on_next = is_on_in;
                    if (midi_channel == PERC_CHANNEL)
                        instr_next = PERC_BASE + PROG_W'(note) - PROG_W'(PERC_LOWEST);
                    else
                        instr_next = PROG_W'(chprog_reg[midi_channel[CH_W-1:0]]);
                    if (op_in == OP_ADVANCE)
                    begin
                        upd.kind    = UPD_AGE;
                        upd.elapsed = elapsed;
                    end
                    else if (ch_ok)
                    begin
                        case (op_in)
                            OP_NOTE_ON, OP_NOTE_OFF:
                            begin
                                // A percussion key-on below the kit range starts nothing.
                                if (!(is_on_in && perc_skip))
                                begin
                                    mode_next  = SM_KEY;
                                    start_next = 1'b1;
                                end
                            end
                            OP_ALL_OFF:
                            begin
                                mode_next  = SM_SLOT;
                                start_next = 1'b1;
                            end
                            OP_PROGRAM: prog_we = 1'b1;
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_SEARCH:
            begin
                // A new note that is not sounding yet goes on to the voice scan.
                if (done && mode_reg == SM_KEY && is_on_reg && !hit)
                begin
                    mode_next  = SM_SCORE;
                    start_next = 1'b1;
                end
            end
            S_RELEASE:
            begin
                if (out_free)
                begin
                    upd.kind   = UPD_RELEASE;
                    upd.idx    = win.idx;
                    upd.ch     = rel_ch;
                    upd.slot_a = active_rd;
                    upd.slot_b = win.slot;
                    act_we     = 1'b1;
                    act_wd     = active_rd - SLOT_W'(1);
                    emit           = 1'b1;
                    cmd_next       = CMD_KEY_OFF;
                    voice_next     = win.idx;
                    instr_out_next = win.prog;
                    tone_next      = '0;
                    kvel_next      = '0;
                    owner_next     = rel_ch;
                    last_next      = (mode_reg == SM_KEY) ||
                                     (mode_reg == SM_SLOT && active_rd == SLOT_W'(1));
                    if (mode_reg == SM_SLOT && active_rd != SLOT_W'(1))
                        start_next = 1'b1;
                end
            end
            S_ASSIGN:
            begin
                if (out_free)
                begin
                    upd.kind   = UPD_ASSIGN;
                    upd.idx    = win.idx;
                    upd.ch     = ch_reg;
                    upd.key    = key_reg;
                    upd.instr  = instr_reg;
                    upd.slot_a = active_rd + SLOT_W'(1);
                    act_we     = 1'b1;
                    act_wd     = active_rd + SLOT_W'(1);
                    emit           = 1'b1;
                    cmd_next       = CMD_KEY_ON;
                    voice_next     = win.idx;
                    instr_out_next = instr_reg;
                    tone_next      = key_reg;
                    kvel_next      = vel_reg;
                    owner_next     = ch_reg;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        outv_next = emit ? 1'b1 : (out_ready ? 1'b0 : outv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= SM_KEY;
            start_reg <= 1'b0;
            is_on_reg <= 1'b0;
            outv_reg  <= 1'b0;
            for (int c = 0; c < MIDI_CHANNELS; c++)
            begin
                active_reg[c] <= '0;
                chprog_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            start_reg <= start_next;
            is_on_reg <= is_on_next;
            outv_reg  <= outv_next;
            if (act_we)
                active_reg[act_wa] <= act_wd;
            if (prog_we)
                chprog_reg[midi_channel[CH_W-1:0]] <= note;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        key_reg       <= key_next;
        vel_reg       <= vel_next;
        instr_reg     <= instr_next;
        cmd_reg       <= cmd_next;
        voice_reg     <= voice_next;
        instr_out_reg <= instr_out_next;
        tone_reg      <= tone_next;
        kvel_reg      <= kvel_next;
        owner_reg     <= owner_next;
        last_reg      <= last_next;
    end

    assign out_valid     = outv_reg;
    assign command       = cmd_reg;
    assign voice         = voice_reg;
    assign instrument    = instr_out_reg;
    assign tone          = tone_reg;
    assign key_velocity  = kvel_reg;
    assign owner_channel = owner_reg;
    assign last          = last_reg;

endmodule

### design/svac_checker.sv
// Port-level assertions for the synthesizer voice allocator, bound to the top level.
// Depends on svac_pkg and synth_voice_allocator.
module svac_checker
    import svac_pkg::*;
#(
    parameter int VOICES        = VOICES_DEF,
    parameter int MIDI_CHANNELS = MIDI_CHANNELS_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [2:0]        operation,
    input logic [CHAN_W-1:0] midi_channel,
    input logic              out_valid,
    input logic              out_ready,
    input logic              command,
    input logic [VIDX_W-1:0] voice,
    input logic              last
);

    // A result that is not the last of its word keeps the input closed.
    a_no_input_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken while a burst of results is unfinished");

    // A key-on always closes the results of its word.
    a_key_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == CMD_KEY_ON |-> last)
        else $error("key-on result not marked last");

    a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> voice < VIDX_W'(VOICES))
        else $error("voice index out of range");

    // A note-off on a valid channel always starts a search.
    a_note_off_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_NOTE_OFF &&
        {1'b0, midi_channel} < (CHAN_W+1)'(MIDI_CHANNELS) |=> !in_ready)
        else $error("note-off finished without a search");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind synth_voice_allocator svac_checker #(
    .VOICES        (VOICES),
    .MIDI_CHANNELS (MIDI_CHANNELS)
) u_svac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .midi_channel (midi_channel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command      (command),
    .voice        (voice),
    .last         (last)
);
